[design/udar_pkg.sv]
// Shared constants, types and period helpers for the up/down auto-repeat counter.
package udar_pkg;

  localparam int VALUE_WIDTH     = 32;
  localparam int HOLD_WIDTH      = 16;
  localparam int PHASE_WIDTH     = 16;
  localparam int PERIOD_WIDTH    = 8;
  localparam int LONG_WIDTH      = 10;
  localparam int VLONG_WIDTH     = 12;
  localparam int CFG_DATA_WIDTH  = 12;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int REM_CNT_WIDTH   = $clog2(PHASE_WIDTH + 1);

  localparam logic [LONG_WIDTH-1:0]   LONG_HOLD_RESET   = LONG_WIDTH'(100);
  localparam logic [VLONG_WIDTH-1:0]  VLONG_HOLD_RESET  = VLONG_WIDTH'(300);
  localparam logic [PERIOD_WIDTH-1:0] SLOW_PERIOD_RESET = PERIOD_WIDTH'(50);
  localparam logic [PERIOD_WIDTH-1:0] FAST_PERIOD_RESET = PERIOD_WIDTH'(10);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_LONG_HOLD   = 2'd0,
    REG_VLONG_HOLD  = 2'd1,
    REG_SLOW_PERIOD = 2'd2,
    REG_FAST_PERIOD = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_status_t;

  // a period of zero acts as a period of one
  function automatic logic [PERIOD_WIDTH-1:0] eff_period(input logic [PERIOD_WIDTH-1:0] p);
    return (p == '0) ? PERIOD_WIDTH'(1) : p;
  endfunction

  // residue of (phase + 1) given residue m of phase
  function automatic logic [PERIOD_WIDTH-1:0] mod_inc(input logic [PERIOD_WIDTH-1:0] m,
                                                      input logic [PERIOD_WIDTH-1:0] p);
    logic [PERIOD_WIDTH:0] s;
    s = {1'b0, m} + (PERIOD_WIDTH+1)'(1);
    return (s == {1'b0, eff_period(p)}) ? '0 : s[PERIOD_WIDTH-1:0];
  endfunction

  // residue of a phase of one
  function automatic logic [PERIOD_WIDTH-1:0] mod_one(input logic [PERIOD_WIDTH-1:0] p);
    return (eff_period(p) == PERIOD_WIDTH'(1)) ? '0 : PERIOD_WIDTH'(1);
  endfunction

endpackage

[design/udar_phase_rem.sv]
// Bit-serial remainder unit: rebuilds the phase residues after a period register write.
module udar_phase_rem (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [udar_pkg::PHASE_WIDTH-1:0]     dividend,
  input  logic [udar_pkg::PERIOD_WIDTH-1:0]    div_a,
  input  logic [udar_pkg::PERIOD_WIDTH-1:0]    div_b,
  output logic [udar_pkg::PERIOD_WIDTH-1:0]    rem_a,
  output logic [udar_pkg::PERIOD_WIDTH-1:0]    rem_b,
  output udar_pkg::rem_status_t                status
);

  logic [udar_pkg::REM_CNT_WIDTH-1:0]  cnt;
  logic                                done;
  logic [udar_pkg::PHASE_WIDTH-1:0]    shreg;
  logic [udar_pkg::PERIOD_WIDTH-1:0]   rem_a_next;
  logic [udar_pkg::PERIOD_WIDTH-1:0]   rem_b_next;
  logic [udar_pkg::PERIOD_WIDTH:0]     ra_wide;
  logic [udar_pkg::PERIOD_WIDTH:0]     rb_wide;
  logic [udar_pkg::PERIOD_WIDTH:0]     pa_wide;
  logic [udar_pkg::PERIOD_WIDTH:0]     pb_wide;
  logic [udar_pkg::PERIOD_WIDTH:0]     ra_sub;
  logic [udar_pkg::PERIOD_WIDTH:0]     rb_sub;

  // restoring remainder, one dividend bit per cycle, both divisors at once
  always_comb begin
    pa_wide    = {1'b0, udar_pkg::eff_period(div_a)};
    pb_wide    = {1'b0, udar_pkg::eff_period(div_b)};
    ra_wide    = {rem_a, shreg[udar_pkg::PHASE_WIDTH-1]};
    rb_wide    = {rem_b, shreg[udar_pkg::PHASE_WIDTH-1]};
    ra_sub     = ra_wide - pa_wide;
    rb_sub     = rb_wide - pb_wide;
    rem_a_next = (ra_wide >= pa_wide) ? ra_sub[udar_pkg::PERIOD_WIDTH-1:0]
                                      : ra_wide[udar_pkg::PERIOD_WIDTH-1:0];
    rem_b_next = (rb_wide >= pb_wide) ? rb_sub[udar_pkg::PERIOD_WIDTH-1:0]
                                      : rb_wide[udar_pkg::PERIOD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= udar_pkg::REM_CNT_WIDTH'(udar_pkg::PHASE_WIDTH);
      end else if (cnt != '0) begin
        cnt  <= cnt - udar_pkg::REM_CNT_WIDTH'(1);
        done <= (cnt == udar_pkg::REM_CNT_WIDTH'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem_a <= '0;
      rem_b <= '0;
    end else if (cnt != '0) begin
      shreg <= {shreg[udar_pkg::PHASE_WIDTH-2:0], 1'b0};
      rem_a <= rem_a_next;
      rem_b <= rem_b_next;
    end
  end

  assign status.busy = (cnt != '0) || done;
  assign status.done = done;

endmodule

[design/updown_button_autorepeat.sv]
// Top level of the up/down button counter with hold-to-repeat at two speeds.
//
// Each input request is one tick carrying the levels of the up and down
// buttons; up wins when both are active. A fresh press steps count_value by
// one, a long hold repeats the step every slow period, a very long hold
// every fast period. Every accepted request yields exactly one result
// (count_value, value_changed, led_off) in the output register in the next cycle.
// Throughput is one request per cycle with in_stall low: the whole tick update
// is one pass of logic from the input ports into the state and output registers.
// The output register keeps its result while out_stall is high; a new request
// is still taken when the output register is empty or being drained.
// Writing a period register starts a bit-serial remainder pass (after a load
// step) that rebuilds the phase residues; in_stall is high while it runs, and
// no request is taken then. Other register writes take effect at once.
// Reset clears the state machine, counters, flags and the value, and loads
// the default thresholds and periods.
module updown_button_autorepeat (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    button_up,
  input  logic                                    button_down,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [udar_pkg::VALUE_WIDTH-1:0] count_value,
  output logic                                    value_changed,
  output logic                                    led_off,
  input  logic                                    cfg_we,
  input  logic [udar_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [udar_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

  typedef enum logic [7:0] {
    S_UP_STEP = 8'b0000_0001,
    S_UP_WAIT = 8'b0000_0010,
    S_UP_SLOW = 8'b0000_0100,
    S_UP_FAST = 8'b0000_1000,
    S_DN_STEP = 8'b0001_0000,
    S_DN_WAIT = 8'b0010_0000,
    S_DN_SLOW = 8'b0100_0000,
    S_DN_FAST = 8'b1000_0000
  } state_t;

  localparam logic [udar_pkg::HOLD_WIDTH-1:0] HOLD_MAX = '1;

  // configuration
  logic [udar_pkg::LONG_WIDTH-1:0]   long_hold;
  logic [udar_pkg::VLONG_WIDTH-1:0]  vlong_hold;
  logic [udar_pkg::PERIOD_WIDTH-1:0] slow_period;
  logic [udar_pkg::PERIOD_WIDTH-1:0] fast_period;

  // tick state
  state_t                            state, state_next;
  logic                              last_up, last_dn;
  logic [udar_pkg::HOLD_WIDTH-1:0]   hold_ticks, hold_next;
  logic [udar_pkg::PHASE_WIDTH-1:0]  phase, phase_next;
  logic [udar_pkg::PERIOD_WIDTH-1:0] slow_mod, slow_mod_next;
  logic [udar_pkg::PERIOD_WIDTH-1:0] fast_mod, fast_mod_next;
  logic                              held_long, held_long_next;
  logic                              held_vlong, held_vlong_next;
  logic                              slow_rep, slow_rep_next;
  logic                              fast_rep, fast_rep_next;
  logic [udar_pkg::VALUE_WIDTH-1:0]  value, value_next;

  logic                              go_up, go_dn, restart, cont;
  logic                              step_up, step_dn, phase_wrap;
  logic [udar_pkg::HOLD_WIDTH:0]     hold_wide, vlim, vlim_p1;
  logic                              accept;

  logic                              rem_start;
  logic [udar_pkg::PERIOD_WIDTH-1:0] rem_slow, rem_fast;
  udar_pkg::rem_status_t             rem_status;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = rem_status.busy || (out_valid && out_stall);
  assign rem_start = cfg_we && ((cfg_index == udar_pkg::REG_SLOW_PERIOD) ||
                                (cfg_index == udar_pkg::REG_FAST_PERIOD));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      long_hold   <= udar_pkg::LONG_HOLD_RESET;
      vlong_hold  <= udar_pkg::VLONG_HOLD_RESET;
      slow_period <= udar_pkg::SLOW_PERIOD_RESET;
      fast_period <= udar_pkg::FAST_PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        udar_pkg::REG_LONG_HOLD:   long_hold   <= cfg_data[udar_pkg::LONG_WIDTH-1:0];
        udar_pkg::REG_VLONG_HOLD:  vlong_hold  <= cfg_data[udar_pkg::VLONG_WIDTH-1:0];
        udar_pkg::REG_SLOW_PERIOD: slow_period <= cfg_data[udar_pkg::PERIOD_WIDTH-1:0];
        udar_pkg::REG_FAST_PERIOD: fast_period <= cfg_data[udar_pkg::PERIOD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // phase residues are rebuilt from the raw phase when a period changes
  udar_phase_rem u_phase_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (phase),
    .div_a    (slow_period),
    .div_b    (fast_period),
    .rem_a    (rem_slow),
    .rem_b    (rem_fast),
    .status   (rem_status)
  );

  // read and timing phases of one tick
  always_comb begin
    go_up   = button_up;
    go_dn   = !button_up && button_down;
    restart = (go_up && !last_up) || (go_dn && !last_dn);
    cont    = (go_up && last_up) || (go_dn && last_dn);

    hold_next       = hold_ticks;
    phase_next      = phase;
    slow_mod_next   = slow_mod;
    fast_mod_next   = fast_mod;
    held_long_next  = held_long;
    held_vlong_next = held_vlong;
    slow_rep_next   = slow_rep;
    fast_rep_next   = fast_rep;

    if (restart) begin
      hold_next       = '0;
      phase_next      = '0;
      slow_mod_next   = '0;
      fast_mod_next   = '0;
      held_long_next  = 1'b0;
      held_vlong_next = 1'b0;
      fast_rep_next   = 1'b0;
    end else if (cont && (hold_ticks != HOLD_MAX)) begin
      hold_next = hold_ticks + udar_pkg::HOLD_WIDTH'(1);
    end

    hold_wide  = {1'b0, hold_next};
    vlim       = (udar_pkg::HOLD_WIDTH+1)'(vlong_hold);
    vlim_p1    = vlim + (udar_pkg::HOLD_WIDTH+1)'(1);
    phase_wrap = (phase_next == '1);

    if ((hold_wide >= vlim) && (hold_wide <= vlim_p1)) begin
      held_vlong_next = 1'b1;
      held_long_next  = 1'b0;
      phase_next      = '0;
      slow_mod_next   = '0;
      fast_mod_next   = '0;
      slow_rep_next   = 1'b0;
    end else if (hold_wide > vlim) begin
      if ((phase_next != '0) && (fast_mod_next == '0)) begin
        fast_rep_next = 1'b1;
        slow_rep_next = 1'b0;
        phase_next    = udar_pkg::PHASE_WIDTH'(1);
        slow_mod_next = udar_pkg::mod_one(slow_period);
        fast_mod_next = udar_pkg::mod_one(fast_period);
      end else begin
        fast_rep_next = 1'b0;
        phase_next    = phase_next + udar_pkg::PHASE_WIDTH'(1);
        slow_mod_next = phase_wrap ? '0 : udar_pkg::mod_inc(slow_mod_next, slow_period);
        fast_mod_next = phase_wrap ? '0 : udar_pkg::mod_inc(fast_mod_next, fast_period);
      end
    end else if (hold_next >= udar_pkg::HOLD_WIDTH'(long_hold)) begin
      held_long_next = 1'b1;
      phase_next     = phase_next + udar_pkg::PHASE_WIDTH'(1);
      slow_mod_next  = phase_wrap ? '0 : udar_pkg::mod_inc(slow_mod_next, slow_period);
      fast_mod_next  = phase_wrap ? '0 : udar_pkg::mod_inc(fast_mod_next, fast_period);
      slow_rep_next  = (phase_next != '0) && (slow_mod_next == '0);
    end
  end

  // update phase: the stepping state machine
  always_comb begin
    state_next = state;
    step_up    = 1'b0;
    step_dn    = 1'b0;
    unique case (state)
      S_UP_STEP: begin
        if (go_up) begin
          step_up    = 1'b1;
          state_next = S_UP_WAIT;
        end else if (go_dn) begin
          state_next = S_DN_STEP;
        end
      end
      S_UP_WAIT: begin
        if (!go_up)              state_next = go_dn ? S_DN_STEP : S_UP_STEP;
        else if (held_long_next) state_next = S_UP_SLOW;
      end
      S_UP_SLOW: begin
        step_up = slow_rep_next;
        if (!go_up)               state_next = go_dn ? S_DN_STEP : S_UP_STEP;
        else if (held_vlong_next) state_next = S_UP_FAST;
      end
      S_UP_FAST: begin
        if (!go_up) state_next = go_dn ? S_DN_STEP : S_UP_STEP;
        else        step_up    = fast_rep_next;
      end
      S_DN_STEP: begin
        if (go_dn) begin
          step_dn    = 1'b1;
          state_next = S_DN_WAIT;
        end else begin
          state_next = S_UP_STEP;
        end
      end
      S_DN_WAIT: begin
        if (!go_dn)              state_next = S_UP_STEP;
        else if (held_long_next) state_next = S_DN_SLOW;
      end
      S_DN_SLOW: begin
        step_dn = slow_rep_next;
        if (!go_dn)               state_next = S_UP_STEP;
        else if (held_vlong_next) state_next = S_DN_FAST;
      end
      S_DN_FAST: begin
        if (!go_dn) state_next = S_UP_STEP;
        else        step_dn    = fast_rep_next;
      end
      default: state_next = S_UP_STEP;
    endcase

    if (step_up)      value_next = value + udar_pkg::VALUE_WIDTH'(1);
    else if (step_dn) value_next = value - udar_pkg::VALUE_WIDTH'(1);
    else              value_next = value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_UP_STEP;
      last_up    <= 1'b0;
      last_dn    <= 1'b0;
      hold_ticks <= '0;
      phase      <= '0;
      slow_mod   <= '0;
      fast_mod   <= '0;
      held_long  <= 1'b0;
      held_vlong <= 1'b0;
      slow_rep   <= 1'b0;
      fast_rep   <= 1'b0;
      value      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        state      <= state_next;
        last_up    <= button_up;
        last_dn    <= button_down;
        hold_ticks <= hold_next;
        phase      <= phase_next;
        slow_mod   <= slow_mod_next;
        fast_mod   <= fast_mod_next;
        held_long  <= held_long_next;
        held_vlong <= held_vlong_next;
        slow_rep   <= slow_rep_next;
        fast_rep   <= fast_rep_next;
        value      <= value_next;
        out_valid  <= 1'b1;
      end else begin
        if (rem_status.done) begin
          slow_mod <= rem_slow;
          fast_mod <= rem_fast;
        end
        if (!out_stall) out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      count_value   <= value_next;
      value_changed <= step_up || step_dn;
      led_off       <= !(button_up || button_down);
    end
  end

  a_no_accept_while_rebuild: assert property (@(posedge clk) disable iff (rst)
    rem_status.busy |-> !accept)
    else $error("request accepted while phase residues are rebuilt");

  a_period_write_stalls: assert property (@(posedge clk) disable iff (rst)
    rem_start |=> in_stall)
    else $error("period write did not stall the input");

  // a released button can still take a slow repeat step, so only the led is checked
  a_idle_tick_led: assert property (@(posedge clk) disable iff (rst)
    (accept && !button_up && !button_down) |=> (out_valid && led_off))
    else $error("tick with no button active did not turn the led off");

  a_step_changes_value: assert property (@(posedge clk) disable iff (rst)
    accept |=> (value_changed == (count_value != $past(value))))
    else $error("value_changed disagrees with the value");

endmodule

[dv/updown_count_checker.sv]
// Checker for the up/down auto-repeat counter: predicts every tick and compares each result.
module updown_count_checker (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  input  logic                                    in_stall,
  input  logic                                    button_up,
  input  logic                                    button_down,
  input  logic                                    out_valid,
  input  logic                                    out_stall,
  input  logic signed [udar_pkg::VALUE_WIDTH-1:0] count_value,
  input  logic                                    value_changed,
  input  logic                                    led_off,
  input  logic                                    cfg_we,
  input  logic [udar_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [udar_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
  output int                                      outstanding,
  output int                                      mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [7:0] {
    UP_STEP = 8'b0000_0001,
    UP_WAIT = 8'b0000_0010,
    UP_SLOW = 8'b0000_0100,
    UP_FAST = 8'b0000_1000,
    DN_STEP = 8'b0001_0000,
    DN_WAIT = 8'b0010_0000,
    DN_SLOW = 8'b0100_0000,
    DN_FAST = 8'b1000_0000
  } press_state_t;

  typedef struct {
    logic signed [udar_pkg::VALUE_WIDTH-1:0] count;
    logic                                    changed;
    logic                                    led;
  } tick_result_t;

  logic [udar_pkg::LONG_WIDTH-1:0]         long_hold;
  logic [udar_pkg::VLONG_WIDTH-1:0]        vlong_hold;
  logic [udar_pkg::PERIOD_WIDTH-1:0]       slow_period;
  logic [udar_pkg::PERIOD_WIDTH-1:0]       fast_period;
  logic                                    prev_up;
  logic                                    prev_dn;
  logic [udar_pkg::HOLD_WIDTH-1:0]         hold_cnt;
  logic [udar_pkg::PHASE_WIDTH-1:0]        phase;
  logic                                    held_long;
  logic                                    held_vlong;
  logic                                    slow_rep;
  logic                                    fast_rep;
  press_state_t                            pstate;
  logic signed [udar_pkg::VALUE_WIDTH-1:0] count;
  tick_result_t                            expected_counts[$];

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // zero period counts as one
  function automatic logic on_beat(input logic [udar_pkg::PHASE_WIDTH-1:0] ph,
                                   input logic [udar_pkg::PERIOD_WIDTH-1:0] per);
    int p;
    p = (per == '0) ? 1 : int'(per);
    return (ph != '0) && ((int'(ph) % p) == 0);
  endfunction

  task automatic step_counter(input logic up, input logic dn);
    logic         serving;
    logic         go_up;
    logic         go_dn;
    int           delta;
    int           vl;
    int           hc;
    tick_result_t r;
    go_up   = up;
    go_dn   = !up && dn;
    serving = up ? prev_up : prev_dn;
    prev_up = up;
    prev_dn = dn;
    delta   = 0;

    // read: fresh press restarts the hold, a continued one counts (saturating)
    if (up || dn) begin
      if (!serving) begin
        phase      = '0;
        held_long  = 1'b0;
        held_vlong = 1'b0;
        hold_cnt   = '0;
        fast_rep   = 1'b0;
      end else if (hold_cnt != '1) begin
        hold_cnt++;
      end
    end

    // timing runs even with no button active
    vl = int'(vlong_hold);
    hc = int'(hold_cnt);
    if (hc >= vl && hc <= vl + 1) begin
      held_vlong = 1'b1;
      held_long  = 1'b0;
      phase      = '0;
      slow_rep   = 1'b0;
    end else if (hc > vl) begin
      if (on_beat(phase, fast_period)) begin
        fast_rep = 1'b1;
        slow_rep = 1'b0;
        phase    = udar_pkg::PHASE_WIDTH'(1);
      end else begin
        fast_rep = 1'b0;
        phase++;
      end
    end else if (hc >= int'(long_hold)) begin
      held_long = 1'b1;
      phase++;
      slow_rep  = on_beat(phase, slow_period);
    end

    case (pstate)
      UP_STEP: begin
        if (go_up) begin
          delta  = 1;
          pstate = UP_WAIT;
        end else if (go_dn) begin
          pstate = DN_STEP;
        end
      end
      UP_WAIT: begin
        if (!go_up) pstate = go_dn ? DN_STEP : UP_STEP;
        else if (held_long) pstate = UP_SLOW;
      end
      UP_SLOW: begin
        if (slow_rep) delta = 1;
        if (!go_up) pstate = go_dn ? DN_STEP : UP_STEP;
        else if (held_vlong) pstate = UP_FAST;
      end
      UP_FAST: begin
        if (!go_up) pstate = go_dn ? DN_STEP : UP_STEP;
        else if (fast_rep) delta = 1;
      end
      DN_STEP: begin
        if (go_dn) begin
          delta  = -1;
          pstate = DN_WAIT;
        end else begin
          pstate = UP_STEP;
        end
      end
      DN_WAIT: begin
        if (!go_dn) pstate = UP_STEP;
        else if (held_long) pstate = DN_SLOW;
      end
      DN_SLOW: begin
        if (slow_rep) delta = -1;
        if (!go_dn) pstate = UP_STEP;
        else if (held_vlong) pstate = DN_FAST;
      end
      default: begin
        if (!go_dn) pstate = UP_STEP;
        else if (fast_rep) delta = -1;
      end
    endcase

    count     = count + delta;
    r.count   = count;
    r.changed = (delta != 0);
    r.led     = !(up || dn);
    expected_counts.push_back(r);
  endtask

  always @(posedge clk) begin : monitor
    tick_result_t want;
    if (rst) begin
      long_hold   = udar_pkg::LONG_HOLD_RESET;
      vlong_hold  = udar_pkg::VLONG_HOLD_RESET;
      slow_period = udar_pkg::SLOW_PERIOD_RESET;
      fast_period = udar_pkg::FAST_PERIOD_RESET;
      prev_up     = 1'b0;
      prev_dn     = 1'b0;
      hold_cnt    = '0;
      phase       = '0;
      held_long   = 1'b0;
      held_vlong  = 1'b0;
      slow_rep    = 1'b0;
      fast_rep    = 1'b0;
      pstate      = UP_STEP;
      count       = '0;
      expected_counts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          udar_pkg::REG_LONG_HOLD:   long_hold   = cfg_data[udar_pkg::LONG_WIDTH-1:0];
          udar_pkg::REG_VLONG_HOLD:  vlong_hold  = cfg_data[udar_pkg::VLONG_WIDTH-1:0];
          udar_pkg::REG_SLOW_PERIOD: slow_period = cfg_data[udar_pkg::PERIOD_WIDTH-1:0];
          udar_pkg::REG_FAST_PERIOD: fast_period = cfg_data[udar_pkg::PERIOD_WIDTH-1:0];
          default: ;
        endcase
      end
      // compare before queuing this edge's request: its result appears in the cycle after
      if (out_valid && !out_stall) begin
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request pending", count_value));
        end else begin
          want = expected_counts.pop_front();
          if (count_value !== want.count)
            report_mismatch($sformatf("count_value %0d, want %0d", count_value, want.count));
          if (value_changed !== want.changed)
            report_mismatch($sformatf("value_changed %b, want %b",
                                      value_changed, want.changed));
          if (led_off !== want.led)
            report_mismatch($sformatf("led_off %b, want %b", led_off, want.led));
        end
      end
      if (in_valid && !in_stall) step_counter(button_up, button_down);
    end
    outstanding <= expected_counts.size();
  end

endmodule

[dv/updown_button_autorepeat_tb.sv]
// Testbench top for the up/down auto-repeat counter: stimulus, flow control and verdict.
module updown_button_autorepeat_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SQUEEZE_TICKS = 300;
  localparam int PHASE_ITEMS   = 80;

  logic                                    clk         = 1'b0;
  logic                                    rst         = 1'b1;
  logic                                    in_valid    = 1'b0;
  logic                                    button_up   = 1'b0;
  logic                                    button_down = 1'b0;
  logic                                    out_stall   = 1'b0;
  logic                                    cfg_we      = 1'b0;
  logic [udar_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index   = '0;
  logic [udar_pkg::CFG_DATA_WIDTH-1:0]     cfg_data    = '0;
  logic                                    in_stall;
  logic                                    out_valid;
  logic signed [udar_pkg::VALUE_WIDTH-1:0] count_value;
  logic                                    value_changed;
  logic                                    led_off;
  int                                      outstanding;
  int                                      mismatches;

  int burst_left = 0;
  int sent       = 0;
  int quiet      = 0;
  int cur_long   = 100;
  int cur_vlong  = 300;
  int cur_slow   = 50;
  int cur_fast   = 10;
  bit squeeze    = 1'b0;
  bit squeezed   = 1'b0;

  updown_button_autorepeat dut (.*);

  updown_count_checker chk (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // one request; the sender may idle between bursts
  task automatic send_tick(input bit up, input bit dn);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 :
            ($urandom_range(0, 7) == 0 ? $urandom_range(8, 20) : $urandom_range(1, 4));
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid    <= 1'b1;
    button_up   <= up;
    button_down <= dn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic hold_run(input bit up, input bit dn, input int n);
    repeat (n) send_tick(up, dn);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // bits above the register width carry noise
  task automatic write_reg(input udar_pkg::cfg_reg_t idx, input int val);
    logic [udar_pkg::CFG_DATA_WIDTH-1:0] mask;
    int                                  keep;
    case (idx)
      udar_pkg::REG_LONG_HOLD:  keep = udar_pkg::LONG_WIDTH;
      udar_pkg::REG_VLONG_HOLD: keep = udar_pkg::VLONG_WIDTH;
      default:                  keep = udar_pkg::PERIOD_WIDTH;
    endcase
    mask = (udar_pkg::CFG_DATA_WIDTH'(1) << keep) - udar_pkg::CFG_DATA_WIDTH'(1);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= (udar_pkg::CFG_DATA_WIDTH'($urandom) & ~mask) |
                 (udar_pkg::CFG_DATA_WIDTH'(val) & mask);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic configure(input int lh, input int vlh, input int sp, input int fp);
    settle();
    write_reg(udar_pkg::REG_LONG_HOLD, lh);
    write_reg(udar_pkg::REG_VLONG_HOLD, vlh);
    write_reg(udar_pkg::REG_SLOW_PERIOD, sp);
    write_reg(udar_pkg::REG_FAST_PERIOD, fp);
    cur_long  = lh;
    cur_vlong = vlh;
    cur_slow  = sp;
    cur_fast  = fp;
  endtask

  function automatic int pick_len(input int span);
    return $urandom_range(0, 1) ? $urandom_range(1, span) : $urandom_range(1, 4);
  endfunction

  function automatic int rest_len();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(4, 30) : $urandom_range(1, 3);
  endfunction

  // mostly press/hold/release sequences sized to reach the repeat modes
  task automatic random_phase(input int n_items);
    int target;
    int span;
    int per;
    int k;
    bit b;
    target = sent + n_items;
    per    = (cur_slow > cur_fast) ? cur_slow : cur_fast;
    if (per < 1) per = 1;
    span = ((cur_long > cur_vlong) ? cur_long : cur_vlong) + 3 * per + 4;
    if (span > 400) span = 400;
    while (sent < target) begin
      k = $urandom_range(0, 9);
      b = 1'($urandom_range(0, 1));
      if (k < 5) begin
        hold_run(b, !b, pick_len(span));
        hold_run(1'b0, 1'b0, rest_len());
      end else if (k < 7) begin
        // down held, up joins and restarts the hold, up lets go: down goes on without a fresh press
        hold_run(1'b0, 1'b1, pick_len(span));
        hold_run(1'b1, 1'b1, $urandom_range(1, 6));
        hold_run(1'b0, 1'b1, pick_len(span));
        if (b) hold_run(1'b1, 1'b0, pick_len(span));
      end else if (k == 7) begin
        hold_run(b, !b, pick_len(span));
        hold_run(!b, b, pick_len(span));
      end else begin
        repeat ($urandom_range(1, 12))
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: press, hold, release, priority, handover
    send_tick(1'b0, 1'b0);
    hold_run(1'b1, 1'b0, 2);
    send_tick(1'b0, 1'b0);
    hold_run(1'b0, 1'b1, 3);
    hold_run(1'b1, 1'b1, 2);
    hold_run(1'b0, 1'b1, 2);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);

    // zero periods, short thresholds
    configure(2, 4, 0, 0);
    hold_run(1'b1, 1'b0, 8);
    send_tick(1'b0, 1'b0);
    hold_run(1'b0, 1'b1, 6);

    // widest settings; a hold that crosses the long threshold
    configure(1023, 4095, 255, 255);
    hold_run(1'b1, 1'b0, 1030);
    hold_run(1'b0, 1'b0, 3);
    hold_run(1'b1, 1'b0, 5);

    configure(1, 2, 1, 1);
    // the receiver holds off while the sender keeps offering requests
    squeeze = 1'b1;
    random_phase(PHASE_ITEMS);
    configure(0, 0, 0, 0);
    random_phase(PHASE_ITEMS);
    configure(3, 8, 2, 0);
    random_phase(PHASE_ITEMS);
    // long threshold above the very-long one
    configure(12, 4, 2, 3);
    random_phase(PHASE_ITEMS);
    configure(100, 300, 50, 10);
    random_phase(PHASE_ITEMS);
    repeat (2) begin
      configure($urandom_range(0, 40), $urandom_range(0, 90),
                $urandom_range(0, 20), $urandom_range(0, 20));
      random_phase(PHASE_ITEMS);
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // result side: stall patterns, plus one long hold-off to back up the input
  initial begin : drain
    int mode;
    int len;
    int k;
    bit s;
    forever begin
      if (squeeze && !squeezed) begin
        out_stall <= 1'b1;
        repeat (SQUEEZE_TICKS) @(posedge clk);
        squeezed = 1'b1;
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(10, 120);
      for (k = 0; k < len && !(squeeze && !squeezed); k++) begin
        case (mode)
          0:       s = 1'b0;
          1:       s = 1'($urandom_range(0, 1));
          2:       s = (k % 3 == 0);
          default: s = ($urandom_range(0, 3) != 0);
        endcase
        out_stall <= s;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
